// ===== design/oriented_box_overlap_test_assert.svh =====
// ----------------------------------------------------------------------------
// Oriented box overlap test: assertion macros
// Concurrent assertion shorthands used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_TEST_ASSERT_SVH
`define ORIENTED_BOX_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OBOT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define OBOT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Same-cycle implication that is also checked while reset is applied.
`define OBOT_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== design/obot_pkg.sv =====
// ----------------------------------------------------------------------------
// Oriented box overlap test: package
// Widths, types and the edge pair tables shared by the modules of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obot_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int DOT_W     = PROD_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int CEN_W     = MAG_W + 1;
   localparam int EXT_W     = MAG_W + 2;
   localparam int NUM_EDGES = 4;
   localparam int NUM_PAIRS = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic        [MAG_W-1:0]   mag_type;
   typedef logic        [CEN_W-1:0]   cen_type;
   typedef logic        [EXT_W-1:0]   ext_type;
   typedef logic        [1:0]         edge_idx_type;
   typedef logic        [3:0]         pair_idx_type;

   // Edges: left u, left v, right u, right v. Each unordered pair of edges is
   // multiplied once; a pair of two different edges is shared by both axes that need it.
   localparam edge_idx_type PAIR_FIRST [NUM_PAIRS] = '{
      2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
   };
   localparam edge_idx_type PAIR_SECOND [NUM_PAIRS] = '{
      2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
   };
   localparam pair_idx_type PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3},
      '{4'd1, 4'd4, 4'd5, 4'd6},
      '{4'd2, 4'd5, 4'd7, 4'd8},
      '{4'd3, 4'd6, 4'd8, 4'd9}
   };

endpackage

// ===== design/obot_abs_dot.sv =====
// ----------------------------------------------------------------------------
// Oriented box overlap test: absolute dot product
// Adds the two partial products of a 2D dot product and returns the magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obot_abs_dot (
   input  obot_pkg::prod_type term_a,
   input  obot_pkg::prod_type term_b,
   output obot_pkg::mag_type  magnitude
);
   import obot_pkg::*;

   dot_type dot_sum;
   dot_type dot_neg;

   assign dot_sum   = dot_type'(term_a) + dot_type'(term_b);
   assign dot_neg   = -dot_sum;
   assign magnitude = dot_sum[DOT_W-1] ? dot_neg[MAG_W-1:0] : dot_sum[MAG_W-1:0];

endmodule

// ===== design/oriented_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// Oriented box overlap test
// Separating axis test of two oriented boxes in 2D, exact fixed point.
// Throughput: one item per cycle, set by the five stage pipeline in which
// each stage holds its item only while the stage after it is full and stalled.
// Reset clears every stage valid bit; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oriented_box_overlap_test (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  obot_pkg::coord_type req_left_center_x,
   input  obot_pkg::coord_type req_left_center_y,
   input  obot_pkg::coord_type req_left_axis_u_x,
   input  obot_pkg::coord_type req_left_axis_u_y,
   input  obot_pkg::coord_type req_left_axis_v_x,
   input  obot_pkg::coord_type req_left_axis_v_y,
   input  obot_pkg::coord_type req_right_center_x,
   input  obot_pkg::coord_type req_right_center_y,
   input  obot_pkg::coord_type req_right_axis_u_x,
   input  obot_pkg::coord_type req_right_axis_u_y,
   input  obot_pkg::coord_type req_right_axis_v_x,
   input  obot_pkg::coord_type req_right_axis_v_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_overlap
);
   import obot_pkg::*;

   logic s1_valid_ff, s1_valid_in, s1_ready;
   logic s2_valid_ff, s2_valid_in, s2_ready;
   logic s3_valid_ff, s3_valid_in, s3_ready;
   logic s4_valid_ff, s4_valid_in, s4_ready;
   logic s5_valid_ff, s5_valid_in, s5_ready;

   coord_type s1_edge_x_ff [NUM_EDGES];
   coord_type s1_edge_x_in [NUM_EDGES];
   coord_type s1_edge_y_ff [NUM_EDGES];
   coord_type s1_edge_y_in [NUM_EDGES];
   diff_type  s1_diff_x_ff, s1_diff_x_in;
   diff_type  s1_diff_y_ff, s1_diff_y_in;

   prod_type s2_ee_x_ff [NUM_PAIRS];
   prod_type s2_ee_x_in [NUM_PAIRS];
   prod_type s2_ee_y_ff [NUM_PAIRS];
   prod_type s2_ee_y_in [NUM_PAIRS];
   prod_type s2_de_x_ff [NUM_EDGES];
   prod_type s2_de_x_in [NUM_EDGES];
   prod_type s2_de_y_ff [NUM_EDGES];
   prod_type s2_de_y_in [NUM_EDGES];

   mag_type s3_ee_ff [NUM_PAIRS];
   mag_type s3_ee_in [NUM_PAIRS];
   mag_type s3_de_ff [NUM_EDGES];
   mag_type s3_de_in [NUM_EDGES];

   ext_type s4_extent_ff [NUM_EDGES];
   ext_type s4_extent_in [NUM_EDGES];
   cen_type s4_centre_ff [NUM_EDGES];
   cen_type s4_centre_in [NUM_EDGES];

   logic [NUM_EDGES-1:0] axis_separates;
   logic s5_overlap_ff, s5_overlap_in;

   // A stage takes a new item when it is empty or its item moves on.
   assign s5_ready  = !s5_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;

   // Stage 1: edge vectors and the centre difference.
   assign s1_edge_x_in[0] = req_left_axis_u_x;
   assign s1_edge_y_in[0] = req_left_axis_u_y;
   assign s1_edge_x_in[1] = req_left_axis_v_x;
   assign s1_edge_y_in[1] = req_left_axis_v_y;
   assign s1_edge_x_in[2] = req_right_axis_u_x;
   assign s1_edge_y_in[2] = req_right_axis_u_y;
   assign s1_edge_x_in[3] = req_right_axis_v_x;
   assign s1_edge_y_in[3] = req_right_axis_v_y;
   assign s1_diff_x_in = diff_type'(req_right_center_x) - diff_type'(req_left_center_x);
   assign s1_diff_y_in = diff_type'(req_right_center_y) - diff_type'(req_left_center_y);

   // Stage 2: partial products of every edge pair and of the centre difference.
   for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
      assign s2_ee_x_in[p] = prod_type'(s1_edge_x_ff[PAIR_FIRST[p]])
                           * prod_type'(s1_edge_x_ff[PAIR_SECOND[p]]);
      assign s2_ee_y_in[p] = prod_type'(s1_edge_y_ff[PAIR_FIRST[p]])
                           * prod_type'(s1_edge_y_ff[PAIR_SECOND[p]]);

      obot_abs_dot u_abs_ee (
         .term_a    (s2_ee_x_ff[p]),
         .term_b    (s2_ee_y_ff[p]),
         .magnitude (s3_ee_in[p])
      );
   end

   for (genvar a = 0; a < NUM_EDGES; a++) begin : g_axis
      assign s2_de_x_in[a] = prod_type'(s1_diff_x_ff) * prod_type'(s1_edge_x_ff[a]);
      assign s2_de_y_in[a] = prod_type'(s1_diff_y_ff) * prod_type'(s1_edge_y_ff[a]);

      // Stage 3: magnitudes of the dot products.
      obot_abs_dot u_abs_de (
         .term_a    (s2_de_x_ff[a]),
         .term_b    (s2_de_y_ff[a]),
         .magnitude (s3_de_in[a])
      );

      // Stage 4: projected extent of both boxes and doubled centre distance.
      assign s4_extent_in[a] = ext_type'(s3_ee_ff[PAIR_OF[0][a]])
                             + ext_type'(s3_ee_ff[PAIR_OF[1][a]])
                             + ext_type'(s3_ee_ff[PAIR_OF[2][a]])
                             + ext_type'(s3_ee_ff[PAIR_OF[3][a]]);
      assign s4_centre_in[a] = {s3_de_ff[a], 1'b0};

      // Stage 5: strict comparison, so touching boxes still overlap.
      assign axis_separates[a] = s4_extent_ff[a] < ext_type'(s4_centre_ff[a]);
   end

   assign s5_overlap_in = ~|axis_separates;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_edge_x_ff <= s1_edge_x_in;
         s1_edge_y_ff <= s1_edge_y_in;
         s1_diff_x_ff <= s1_diff_x_in;
         s1_diff_y_ff <= s1_diff_y_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ee_x_ff <= s2_ee_x_in;
         s2_ee_y_ff <= s2_ee_y_in;
         s2_de_x_ff <= s2_de_x_in;
         s2_de_y_ff <= s2_de_y_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ee_ff <= s3_ee_in;
         s3_de_ff <= s3_de_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_extent_ff <= s4_extent_in;
         s4_centre_ff <= s4_centre_in;
      end
      if (s5_ready && s4_valid_ff) begin
         s5_overlap_ff <= s5_overlap_in;
      end
   end

   assign rsp_valid   = s5_valid_ff;
   assign rsp_overlap = s5_overlap_ff;

endmodule

// ===== design/obot_checker.sv =====
// ----------------------------------------------------------------------------
// Oriented box overlap test: port checker
// Watches the ports of the top level and checks handshake and flow behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oriented_box_overlap_test_assert.svh"

module obot_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_overlap
);

   // A stalled result stays offered and unchanged.
   `OBOT_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `OBOT_ASSERT_NEXT(a_rsp_data_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_overlap))

   // The pipeline only refuses an item when the result stage is full and stalled.
   `OBOT_ASSERT_IMPL(a_req_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // No result is offered in the cycle after reset.
   `OBOT_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) && !reset, !rsp_valid)

endmodule

bind oriented_box_overlap_test obot_checker u_obot_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_overlap (rsp_overlap)
);

// ===== tb/oriented_box_overlap_test_tb.sv =====
// ----------------------------------------------------------------------------
// Oriented box overlap test: testbench
// Streams pairs of oriented boxes through the block and compares each overlap
// flag with one computed here by exact wide integer arithmetic. A directed
// set of edge cases comes first, then random pairs under several idle mixes,
// a long result stall and a pause of the sender until the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oriented_box_overlap_test_tb;
   import obot_pkg::*;

   localparam int        CYCLE_LIMIT = 200_000;
   localparam int        DRAIN_TAIL  = 12;
   localparam int        SHOWN_ERRS  = 10;
   localparam coord_type ONE         = 32'sh0001_0000;
   localparam coord_type C_MAX       = 32'sh7FFF_FFFF;
   localparam coord_type C_MIN       = 32'sh8000_0000;

   typedef struct packed {
      coord_type left_center_x;
      coord_type left_center_y;
      coord_type left_axis_u_x;
      coord_type left_axis_u_y;
      coord_type left_axis_v_x;
      coord_type left_axis_v_y;
      coord_type right_center_x;
      coord_type right_center_y;
      coord_type right_axis_u_x;
      coord_type right_axis_u_y;
      coord_type right_axis_v_x;
      coord_type right_axis_v_y;
   } box_pair_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   box_pair_type req_pair = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic         rsp_overlap;

   bit          expected_overlaps[$];
   bit          wanted_overlap;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          hold_left = 0;
   int unsigned error_count = 0;
   int unsigned result_count = 0;
   int unsigned cycle_count = 0;

   oriented_box_overlap_test dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_left_center_x  (req_pair.left_center_x),
      .req_left_center_y  (req_pair.left_center_y),
      .req_left_axis_u_x  (req_pair.left_axis_u_x),
      .req_left_axis_u_y  (req_pair.left_axis_u_y),
      .req_left_axis_v_x  (req_pair.left_axis_v_x),
      .req_left_axis_v_y  (req_pair.left_axis_v_y),
      .req_right_center_x (req_pair.right_center_x),
      .req_right_center_y (req_pair.right_center_y),
      .req_right_axis_u_x (req_pair.right_axis_u_x),
      .req_right_axis_u_y (req_pair.right_axis_u_y),
      .req_right_axis_v_x (req_pair.right_axis_v_x),
      .req_right_axis_v_y (req_pair.right_axis_v_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_overlap        (rsp_overlap)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: a long hold-off takes precedence over the random stalls.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_overlaps.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRS)
               $display("Result %0d: overlap %0b arrived with nothing pending",
                        result_count, rsp_overlap);
         end else begin
            wanted_overlap = expected_overlaps.pop_front();
            if (rsp_overlap !== wanted_overlap) begin
               error_count++;
               if (error_count <= SHOWN_ERRS)
                  $display("Result %0d: overlap expected %0b, got %0b",
                           result_count, wanted_overlap, rsp_overlap);
            end
         end
      end
   end

   // Each edge is tried as an axis; the boxes are apart on it when the summed
   // edge projections fall short of twice the projected centre offset.
   function automatic bit predict_overlap(box_pair_type p);
      logic signed [127:0] ex[4];
      logic signed [127:0] ey[4];
      logic signed [127:0] dx, dy, dot, extent, offset;
      bit                  hit;
      hit   = 1'b1;
      ex[0] = $signed(p.left_axis_u_x);
      ey[0] = $signed(p.left_axis_u_y);
      ex[1] = $signed(p.left_axis_v_x);
      ey[1] = $signed(p.left_axis_v_y);
      ex[2] = $signed(p.right_axis_u_x);
      ey[2] = $signed(p.right_axis_u_y);
      ex[3] = $signed(p.right_axis_v_x);
      ey[3] = $signed(p.right_axis_v_y);
      dx    = $signed(p.right_center_x);
      dx    = dx - $signed(p.left_center_x);
      dy    = $signed(p.right_center_y);
      dy    = dy - $signed(p.left_center_y);
      for (int a = 0; a < 4; a++) begin
         extent = '0;
         for (int k = 0; k < 4; k++) begin
            dot    = ex[k] * ex[a] + ey[k] * ey[a];
            extent = extent + ((dot < 0) ? -dot : dot);
         end
         dot    = dx * ex[a] + dy * ey[a];
         offset = ((dot < 0) ? -dot : dot) * 2;
         if (extent < offset)
            hit = 1'b0;
      end
      return hit;
   endfunction

   task automatic send_pair(input box_pair_type p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pair  <= p;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_overlaps.push_back(predict_overlap(p));
   endtask

   task automatic send_boxes(input coord_type lcx, lcy, lux, luy, lvx, lvy,
                             input coord_type rcx, rcy, rux, ruy, rvx, rvy);
      send_pair('{lcx, lcy, lux, luy, lvx, lvy, rcx, rcy, rux, ruy, rvx, rvy});
   endtask

   task automatic wait_until_empty();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_overlaps.size() != 0);
   endtask

   function automatic coord_type rand_coord(int unsigned span);
      case ($urandom_range(15))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3:       return coord_type'($urandom);
         default: return $signed($urandom) >>> (31 - span);
      endcase
   endfunction

   // Mostly independent random boxes at varied scales; some pairs are a copy
   // of the first box shifted by one of its edges, so they touch or nearly do.
   task automatic send_random_pair();
      box_pair_type p;
      int unsigned  cspan, espan;
      cspan = $urandom_range(30, 4);
      espan = $urandom_range(30, 4);
      p.left_center_x  = rand_coord(cspan);
      p.left_center_y  = rand_coord(cspan);
      p.left_axis_u_x  = rand_coord(espan);
      p.left_axis_u_y  = rand_coord(espan);
      p.left_axis_v_x  = rand_coord(espan);
      p.left_axis_v_y  = rand_coord(espan);
      p.right_center_x = rand_coord(cspan);
      p.right_center_y = rand_coord(cspan);
      p.right_axis_u_x = rand_coord(espan);
      p.right_axis_u_y = rand_coord(espan);
      p.right_axis_v_x = rand_coord(espan);
      p.right_axis_v_y = rand_coord(espan);
      if ($urandom_range(3) == 0) begin
         p.left_center_x  = $signed($urandom) >>> 8;
         p.left_center_y  = $signed($urandom) >>> 8;
         p.left_axis_u_x  = $signed($urandom) >>> 8;
         p.left_axis_u_y  = $signed($urandom) >>> 8;
         p.left_axis_v_x  = $signed($urandom) >>> 8;
         p.left_axis_v_y  = $signed($urandom) >>> 8;
         p.right_axis_u_x = $urandom_range(1) ? p.left_axis_u_x : -p.left_axis_u_x;
         p.right_axis_u_y = $urandom_range(1) ? p.left_axis_u_y : -p.left_axis_u_y;
         p.right_axis_v_x = p.left_axis_v_x;
         p.right_axis_v_y = p.left_axis_v_y;
         if ($urandom_range(1)) begin
            p.right_axis_u_x = p.left_axis_u_x;
            p.right_axis_u_y = p.left_axis_u_y;
         end
         if ($urandom_range(1)) begin
            p.right_center_x = p.left_center_x + p.left_axis_u_x;
            p.right_center_y = p.left_center_y + p.left_axis_u_y;
         end else begin
            p.right_center_x = p.left_center_x - p.left_axis_v_x;
            p.right_center_y = p.left_center_y - p.left_axis_v_y;
         end
         p.right_center_x = p.right_center_x + coord_type'($urandom_range(2)) - 1;
         p.right_center_y = p.right_center_y + coord_type'($urandom_range(2)) - 1;
      end
      send_pair(p);
   endtask

   task automatic test_edge_cases();
      coord_type two;
      two = 2 * ONE;
      // Identical boxes, coincident centres.
      send_boxes(0, 0, two, 0, 0, two, 0, 0, two, 0, 0, two);
      // Side by side touching, then one step apart, then far apart.
      send_boxes(0, 0, two, 0, 0, two, two, 0, two, 0, 0, two);
      send_boxes(0, 0, two, 0, 0, two, two + 1, 0, two, 0, 0, two);
      send_boxes(0, 0, two, 0, 0, two, 100 * ONE, 50 * ONE, two, 0, 0, two);
      // A diamond touching a square at one corner, then just clear of it.
      send_boxes(0, 0, two, 0, 0, two, two, 0, ONE, ONE, -ONE, ONE);
      send_boxes(0, 0, two, 0, 0, two, two + 1, 0, ONE, ONE, -ONE, ONE);
      // Zero edge vectors everywhere, so no axis can separate.
      send_boxes(ONE, -ONE, 0, 0, 0, 0, 7 * ONE, 3 * ONE, 0, 0, 0, 0);
      // A point box inside and outside a square.
      send_boxes(ONE / 2, 0, 0, 0, 0, 0, 0, 0, two, 0, 0, two);
      send_boxes(3 * ONE, 0, 0, 0, 0, 0, 0, 0, two, 0, 0, two);
      // Collinear edges give a flat box.
      send_boxes(0, 0, two, two, ONE, ONE, 0, 3 * ONE, two, 0, 0, two);
      // Extremes of every field.
      send_boxes(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                 C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      send_boxes(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                 C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      send_boxes(C_MIN, C_MIN, ONE, 0, 0, ONE, C_MAX, C_MAX, ONE, 0, 0, ONE);
      send_boxes(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
                 C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
      send_boxes(C_MAX, C_MIN, 1, 0, 0, 1, C_MIN, C_MAX, -1, -1, 1, -1);
      send_boxes(-1, -1, C_MIN, C_MIN, C_MIN, C_MAX,
                 C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
      wait_until_empty();
   endtask

   task automatic test_random_pairs(input int unsigned count);
      repeat (count)
         send_random_pair();
      wait_until_empty();
   endtask

   task automatic test_result_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 300;
      repeat (40)
         send_random_pair();
      wait_until_empty();
      repeat (20)
         send_random_pair();
      wait_until_empty();
   endtask

   initial begin
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 61;
      test_edge_cases();
      test_random_pairs(450);

      send_idle_pct = 61;
      recv_idle_pct = 30;
      test_random_pairs(450);

      test_result_stall();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pairs(390);

      repeat (DRAIN_TAIL)
         @(posedge clock);
      if (error_count == 0 && expected_overlaps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== oriented_box_overlap_test.f =====
+incdir+design
design/obot_pkg.sv
design/obot_abs_dot.sv
design/oriented_box_overlap_test.sv
design/obot_checker.sv
tb/oriented_box_overlap_test_tb.sv
